>>> rtl/core/svpwm_pkg.sv
package svpwm_pkg;

  // Default build-time settings
  localparam int unsigned SineEntriesDefault = 601;
  localparam int unsigned CountWidthDefault  = 16;

  // Field widths
  localparam int unsigned CountW  = 16;
  localparam int unsigned AngleW  = 12;
  localparam int unsigned SectorW = 3;

  // Angle geometry in tenths of a degree
  localparam int unsigned TenthsPerSector = 600;
  localparam int unsigned TenthsPerTurn   = 3600;

  // Sine store: one entry per tenth of a degree across one sector, both ends included
  localparam int unsigned SineDepth = TenthsPerSector + 1;
  localparam int unsigned SineAddrW = $clog2(SineDepth);
  localparam int unsigned SineW     = 16;

  localparam logic [CountW-1:0] PeriodReset = 16'd1000;
  localparam logic [63:0]       PiQ30       = 64'd3373259426;

  typedef enum logic [SectorW-1:0] {
    Sector1 = 3'd1,
    Sector2 = 3'd2,
    Sector3 = 3'd3,
    Sector4 = 3'd4,
    Sector5 = 3'd5,
    Sector6 = 3'd6
  } sector_e;

  typedef struct packed {
    logic [CountW-1:0] ref_amplitude;
    logic [AngleW-1:0] vector_angle;
  } in_beat_t;

  typedef struct packed {
    logic [CountW-1:0]  phase_a_duty;
    logic [CountW-1:0]  phase_b_duty;
    logic [CountW-1:0]  phase_c_duty;
    logic [SectorW-1:0] sector_number;
  } out_beat_t;

endpackage

>>> rtl/core/svpwm_duty_calculator.sv
// Seven-segment space vector PWM duty calculator.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat carries a
// reference amplitude in timer counts and a vector angle in tenths of a
// degree. Output channel (out_valid_o / out_stall_i / out_data_o): one beat
// carries the three center-aligned compare values and the sector 1..6.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the half
// PWM period; always ready. Write it only while the pipeline is empty.
//
// Throughput: one beat per cycle while out_stall_i is low. A beat passes
// through four register stages (sine read, multiplies, phase table, clamp).
// Reset: the period returns to 1000 and the pipeline empties. Then a fill
// pass loads the 601 entries of the sine store, one entry a cycle;
// in_stall_o stays high until the pass ends.
// Stall: when out_stall_i holds, the output beat holds and the stages
// behind it fill up one by one; in_stall_o rises once every stage is full.
module svpwm_duty_calculator
  import svpwm_pkg::*;
#(
  parameter int unsigned SINE_ENTRIES = SineEntriesDefault,
  parameter int unsigned COUNT_WIDTH  = CountWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_beat_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_beat_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  // Effective count width: counts wider than the ports are cut back to 16 bits
  localparam int unsigned VrefW = (COUNT_WIDTH < CountW) ? COUNT_WIDTH : CountW;
  localparam int unsigned ProdW = VrefW + SineW + 1;
  localparam int unsigned DblW  = VrefW + 3;

  localparam logic [63:0] LastIdx  = (SINE_ENTRIES > 1) ? 64'(SINE_ENTRIES - 1) : 64'd1;
  localparam logic [63:0] SineDiv  = 64'(3) * LastIdx;
  localparam logic [63:0] Tenths64 = 64'(TenthsPerSector);

  // Sine of each tenth of a degree in one sector, Q1.15, from a Taylor series.
  function automatic logic [SineDepth*SineW-1:0] build_sine();
    logic [SineDepth*SineW-1:0] tab;
    logic [63:0] idx;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sum;
    tab = '0;
    for (int i = 0; i < SineDepth; i++) begin
      idx = (64'(i) * LastIdx + 64'd300) / Tenths64;
      if (idx > LastIdx) begin
        idx = LastIdx;
      end
      x   = (idx * PiQ30) / SineDiv;
      x2  = (x * x) >> 30;
      sum = x;
      t   = ((x * x2) >> 30) / 64'd6;
      sum = sum - t;
      t   = ((t * x2) >> 30) / 64'd20;
      sum = sum + t;
      t   = ((t * x2) >> 30) / 64'd42;
      sum = sum - t;
      t   = ((t * x2) >> 30) / 64'd72;
      sum = sum + t;
      tab[i*SineW +: SineW] = SineW'((sum + 64'd16384) >> 15);
    end
    return tab;
  endfunction

  localparam logic [SineDepth*SineW-1:0] SineTab = build_sine();

  // Drop negative times, halve, clamp to the period.
  function automatic logic [CountW-1:0] finish(logic signed [DblW-1:0] dbl,
                                               logic [VrefW-1:0] per);
    logic [DblW-2:0] half;
    logic [VrefW-1:0] res;
    half = dbl[DblW-1:1];
    if (dbl[DblW-1]) begin
      res = '0;
    end else if (half > (DblW-1)'(per)) begin
      res = per;
    end else begin
      res = half[VrefW-1:0];
    end
    return CountW'(res);
  endfunction

  // ---------------------------------------------------------------------
  // Config register and sine store fill
  // ---------------------------------------------------------------------
  logic [VrefW-1:0]     period_q;
  logic                 fill_active_q;
  logic [SineAddrW-1:0] fill_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= PeriodReset[VrefW-1:0];
      fill_active_q <= 1'b1;
      fill_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        period_q <= cfg_data_i[VrefW-1:0];
      end
      if (fill_active_q) begin
        if (fill_q == SineAddrW'(SineDepth - 1)) begin
          fill_active_q <= 1'b0;
        end else begin
          fill_q <= fill_q + SineAddrW'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage enables: a stage advances when empty or when the next one moves
  // ---------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic en1, en2, en3, en_out, accept;

  assign en_out     = !out_valid_q || !out_stall_i;
  assign en3        = !s3_valid_q || en_out;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_stall_o = fill_active_q || !en1;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    s1_valid_q  <= accept;
      if (en2)    s2_valid_q  <= s1_valid_q;
      if (en3)    s3_valid_q  <= s2_valid_q;
      if (en_out) out_valid_q <= s3_valid_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: wrap the angle, find sector and position, read both sines
  // ---------------------------------------------------------------------
  logic [AngleW-1:0]    ang_w;
  logic [AngleW-1:0]    rel_full;
  logic [SineAddrW-1:0] rel;
  sector_e              sector_d;
  logic [SineAddrW-1:0] addr_t1;
  logic [SineW-1:0]     sin_t1, sin_t2;

  always_comb begin
    ang_w = in_data_i.vector_angle;
    if (ang_w >= AngleW'(TenthsPerTurn)) begin
      ang_w = ang_w - AngleW'(TenthsPerTurn);
    end
    if (ang_w < AngleW'(TenthsPerSector)) begin
      sector_d = Sector1;
      rel_full = ang_w;
    end else if (ang_w < AngleW'(2 * TenthsPerSector)) begin
      sector_d = Sector2;
      rel_full = ang_w - AngleW'(TenthsPerSector);
    end else if (ang_w < AngleW'(3 * TenthsPerSector)) begin
      sector_d = Sector3;
      rel_full = ang_w - AngleW'(2 * TenthsPerSector);
    end else if (ang_w < AngleW'(4 * TenthsPerSector)) begin
      sector_d = Sector4;
      rel_full = ang_w - AngleW'(3 * TenthsPerSector);
    end else if (ang_w < AngleW'(5 * TenthsPerSector)) begin
      sector_d = Sector5;
      rel_full = ang_w - AngleW'(4 * TenthsPerSector);
    end else begin
      sector_d = Sector6;
      rel_full = ang_w - AngleW'(5 * TenthsPerSector);
    end
    rel     = rel_full[SineAddrW-1:0];
    addr_t1 = SineAddrW'(TenthsPerSector) - rel;
  end

  svpwm_ram #(
    .Width (SineW),
    .Depth (SineDepth)
  ) u_sine_ram (
    .clk_i     (clk_i),
    .we_i      (fill_active_q),
    .waddr_i   (fill_q),
    .wdata_i   (SineTab[fill_q*SineW +: SineW]),
    .re_i      (en1),
    .raddr_a_i (addr_t1),
    .raddr_b_i (rel),
    .rdata_a_o (sin_t1),
    .rdata_b_o (sin_t2)
  );

  logic [VrefW-1:0] s1_vref_q;
  sector_e          s1_sector_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_vref_q   <= in_data_i.ref_amplitude[VrefW-1:0];
      s1_sector_q <= sector_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: active times, rounded to whole counts
  // ---------------------------------------------------------------------
  logic [ProdW-1:0] prod_t1, prod_t2;
  logic [VrefW-1:0] s2_t1_q, s2_t2_q;
  sector_e          s2_sector_q;

  assign prod_t1 = ProdW'(s1_vref_q) * ProdW'(sin_t1) + ProdW'(16384);
  assign prod_t2 = ProdW'(s1_vref_q) * ProdW'(sin_t2) + ProdW'(16384);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_t1_q     <= prod_t1[15 +: VrefW];
      s2_t2_q     <= prod_t2[15 +: VrefW];
      s2_sector_q <= s1_sector_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: phase times in half counts by the six-sector table
  // ---------------------------------------------------------------------
  logic signed [DblW-1:0] ps, t1s, t2s;
  logic signed [DblW-1:0] v_sum, v_t1, v_t2, v_t0;
  logic signed [DblW-1:0] a_d, b_d, c_d;
  logic signed [DblW-1:0] s3_a_q, s3_b_q, s3_c_q;
  sector_e                s3_sector_q;

  always_comb begin
    ps    = $signed(DblW'(period_q));
    t1s   = $signed(DblW'(s2_t1_q));
    t2s   = $signed(DblW'(s2_t2_q));
    v_sum = ps + t1s + t2s;
    v_t1  = ps + t1s - t2s;
    v_t2  = ps - t1s + t2s;
    v_t0  = ps - t1s - t2s;
    case (s2_sector_q)
      Sector1: begin
        a_d = v_sum; b_d = v_t2;  c_d = v_t0;
      end
      Sector2: begin
        a_d = v_t1;  b_d = v_sum; c_d = v_t0;
      end
      Sector3: begin
        a_d = v_t0;  b_d = v_sum; c_d = v_t2;
      end
      Sector4: begin
        a_d = v_t0;  b_d = v_t1;  c_d = v_sum;
      end
      Sector5: begin
        a_d = v_t2;  b_d = v_t0;  c_d = v_sum;
      end
      default: begin
        a_d = v_sum; b_d = v_t0;  c_d = v_t1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_a_q      <= a_d;
      s3_b_q      <= b_d;
      s3_c_q      <= c_d;
      s3_sector_q <= s2_sector_q;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: clamp and hold until taken
  // ---------------------------------------------------------------------
  out_beat_t out_q;

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_q.phase_a_duty  <= finish(s3_a_q, period_q);
      out_q.phase_b_duty  <= finish(s3_b_q, period_q);
      out_q.phase_c_duty  <= finish(s3_c_q, period_q);
      out_q.sector_number <= s3_sector_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/svpwm_ram.sv
module svpwm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
